// ===== rtl/core/sfpled_pkg.sv =====
// ----------------------------------------------------------------------------
// SFP port LED controller package
// Payload types and ID/diagnostics bit masks shared by the core modules.
// ----------------------------------------------------------------------------
package sfpled_pkg;

   // copper indications in the module ID page
   localparam logic [7:0] COPPER_B3_MASK = 8'h03;
   localparam logic [7:0] COPPER_B8_MASK = 8'h0C;
   // loss-of-signal bit in diagnostics status byte
   localparam logic [7:0] LOS_BIT_MASK   = 8'h02;

   // reset value of the activity ownership register
   localparam logic ACTIVITY_EXTERNAL_RESET = 1'b0;

   typedef struct packed {
      logic        sfp_present;
      logic        id_read_ok;
      logic [7:0]  id_byte3;
      logic [7:0]  id_byte8;
      logic        diag_read_ok;
      logic [7:0]  diag_status;
      logic        netdev_found;
      logic        oper_up;
      logic        if_running;
      logic [63:0] tx_count;
      logic [63:0] rx_count;
   } req_type;

   typedef struct packed {
      logic link_lamp;
      logic activity_lamp;
      logic link_state;
      logic dac_detected;
   } rsp_type;

endpackage

// ===== rtl/core/sfp_port_led_controller_core.sv =====
// ----------------------------------------------------------------------------
// SFP port LED controller core
// Tracks module presence, cable type, carrier and traffic per poll tick and
// drives the link and activity LED levels.
//
// Usage:
//   req_* carries one poll tick per transfer (valid/stall). rsp_* returns one
//   result per tick: LED levels, the carrier flag and the cable type.
//   csr_write_enable/csr_write_data set the activity ownership bit; write it
//   only while no tick is in flight.
// Path: a tick transfers into the input register, then passes through the
//   update logic into the result register, from which the result is offered
//   on the response channel.
// Throughput: one tick per cycle while rsp_stall is low; the state update is
//   a single pass of logic between the input register and result register.
// Stall: a stalled result holds in the result register; the input register
//   still takes one more tick, then req_stall rises until the result leaves.
// Reset: synchronous; all port state, LED levels and the ownership bit
//   clear, both channels empty.
// ----------------------------------------------------------------------------
module sfp_port_led_controller_core
   import sfpled_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_write_enable,
   input  logic    csr_write_data
);

   logic    tick_valid;
   logic    tick_take;
   req_type tick_data;
   rsp_type result;
   logic    step;

   sfpled_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .tick_valid (tick_valid),
      .tick_take  (tick_take),
      .tick_data  (tick_data)
   );

   // one tick is processed when it can land in the result register
   assign step = tick_valid && tick_take;

   sfpled_update u_update (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step             (step),
      .tick             (tick_data),
      .result           (result)
   );

   sfpled_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (tick_valid),
      .load_ready (tick_take),
      .load_data  (result),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== rtl/core/sfpled_in_reg.sv =====
// ----------------------------------------------------------------------------
// SFP LED input register
// Captures one poll tick from the request channel and holds it until the
// update stage takes it.
// ----------------------------------------------------------------------------
module sfpled_in_reg
   import sfpled_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    tick_valid,
   input  logic    tick_take,
   output req_type tick_data
);

   logic    valid_ff, valid_in;
   req_type data_ff;

   // stall while a held tick cannot move on
   assign req_stall = valid_ff && !tick_take;

   always_comb begin
      valid_in = valid_ff;
      if (!req_stall) begin
         valid_in = req_valid;
      end
   end

   // capture on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         data_ff <= req_data;
      end
   end

   assign tick_valid = valid_ff;
   assign tick_data  = data_ff;

endmodule

// ===== rtl/core/sfpled_update.sv =====
// ----------------------------------------------------------------------------
// SFP LED state update
// Holds port state and the activity ownership register, and works out the
// next state and LED levels for one poll tick.
// ----------------------------------------------------------------------------
module sfpled_update
   import sfpled_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_write_enable,
   input  logic    csr_write_data,
   input  logic    step,
   input  req_type tick,
   output rsp_type result
);

   logic        activity_external_ff;
   logic        present_seen_ff,   present_seen_in;
   logic        carrier_seen_ff,   carrier_seen_in;
   logic        cable_dac_ff,      cable_dac_in;
   logic        netdev_bound_ff,   netdev_bound_in;
   logic [63:0] prev_tx_ff,        prev_tx_in;
   logic [63:0] prev_rx_ff,        prev_rx_in;
   logic        blink_phase_ff,    blink_phase_in;
   logic        link_level_ff,     link_level_in;
   logic        activity_level_ff, activity_level_in;

   // next state for one tick
   always_comb begin
      logic done;
      logic carrier;
      done              = 1'b0;
      carrier           = 1'b0;
      present_seen_in   = present_seen_ff;
      carrier_seen_in   = carrier_seen_ff;
      cable_dac_in      = cable_dac_ff;
      netdev_bound_in   = netdev_bound_ff;
      prev_tx_in        = prev_tx_ff;
      prev_rx_in        = prev_rx_ff;
      blink_phase_in    = blink_phase_ff;
      link_level_in     = link_level_ff;
      activity_level_in = activity_level_ff;

      // presence change: removal clears, insertion classifies the cable
      if (tick.sfp_present != present_seen_ff) begin
         present_seen_in = tick.sfp_present;
         link_level_in   = 1'b0;
         if (!tick.sfp_present) begin
            if (!activity_external_ff) activity_level_in = 1'b0;
            carrier_seen_in = 1'b0;
            cable_dac_in    = 1'b0;
         end else begin
            cable_dac_in = tick.id_read_ok &&
                           (((tick.id_byte3 & COPPER_B3_MASK) != 8'h00) ||
                            ((tick.id_byte8 & COPPER_B8_MASK) != 8'h00));
            if (!activity_external_ff) activity_level_in = 1'b1;
         end
      end

      if (!tick.sfp_present) begin
         done = 1'b1;
      end

      // bind the interface once found; hold link off until then
      if (!done) begin
         if (tick.netdev_found) netdev_bound_in = 1'b1;
         if (!netdev_bound_in) begin
            link_level_in = 1'b0;
            if (!activity_external_ff) activity_level_in = 1'b1;
            done = 1'b1;
         end
      end

      // carrier from operstate for copper, from loss of signal for fibre
      if (!done) begin
         if (cable_dac_in) begin
            carrier = tick.oper_up;
         end else begin
            carrier = tick.diag_read_ok && ((tick.diag_status & LOS_BIT_MASK) == 8'h00);
         end
         if (carrier != carrier_seen_in) begin
            carrier_seen_in = carrier;
            link_level_in   = carrier;
            if (carrier) begin
               if (!activity_external_ff) activity_level_in = 1'b0;
               prev_tx_in     = '0;
               prev_rx_in     = '0;
               blink_phase_in = 1'b0;
            end else begin
               if (!activity_external_ff) activity_level_in = 1'b1;
            end
         end
         if (!carrier || !tick.if_running) done = 1'b1;
      end

      // toggle on traffic, drop on idle
      if (!done) begin
         if ((tick.tx_count != prev_tx_in) || (tick.rx_count != prev_rx_in)) begin
            blink_phase_in = !blink_phase_in;
            if (!activity_external_ff) activity_level_in = blink_phase_in;
            prev_tx_in = tick.tx_count;
            prev_rx_in = tick.rx_count;
         end else if (blink_phase_in) begin
            blink_phase_in = 1'b0;
            if (!activity_external_ff) activity_level_in = 1'b0;
         end
      end
   end

   // result reflects the state after this tick
   assign result.link_lamp     = link_level_in;
   assign result.activity_lamp = activity_level_in;
   assign result.link_state    = carrier_seen_in;
   assign result.dac_detected  = cable_dac_in;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         activity_external_ff <= ACTIVITY_EXTERNAL_RESET;
      end else if (csr_write_enable) begin
         activity_external_ff <= csr_write_data;
      end
   end

   // advance port state on each tick
   always_ff @(posedge clock) begin
      if (reset) begin
         present_seen_ff   <= 1'b0;
         carrier_seen_ff   <= 1'b0;
         cable_dac_ff      <= 1'b0;
         netdev_bound_ff   <= 1'b0;
         prev_tx_ff        <= '0;
         prev_rx_ff        <= '0;
         blink_phase_ff    <= 1'b0;
         link_level_ff     <= 1'b0;
         activity_level_ff <= 1'b0;
      end else if (step) begin
         present_seen_ff   <= present_seen_in;
         carrier_seen_ff   <= carrier_seen_in;
         cable_dac_ff      <= cable_dac_in;
         netdev_bound_ff   <= netdev_bound_in;
         prev_tx_ff        <= prev_tx_in;
         prev_rx_ff        <= prev_rx_in;
         blink_phase_ff    <= blink_phase_in;
         link_level_ff     <= link_level_in;
         activity_level_ff <= activity_level_in;
      end
   end

   // link LED always follows the stored carrier
   a_link_tracks_carrier: assert property (@(posedge clock) disable iff (reset)
      link_level_ff == carrier_seen_ff)
      else $error("link LED differs from carrier flag");

   // no module means no carrier, no cable type and link off
   a_absent_clear: assert property (@(posedge clock) disable iff (reset)
      !present_seen_ff |-> (!carrier_seen_ff && !cable_dac_ff && !link_level_ff))
      else $error("state not cleared while module absent");

   // carrier is only ever seen through a bound interface
   a_carrier_needs_bind: assert property (@(posedge clock) disable iff (reset)
      carrier_seen_ff |-> netdev_bound_ff)
      else $error("carrier without bound interface");

   // externally owned activity LED keeps its level across a tick
   a_external_holds: assert property (@(posedge clock) disable iff (reset)
      (step && activity_external_ff) |=> $stable(activity_level_ff))
      else $error("activity LED written while externally owned");

endmodule

// ===== rtl/core/sfpled_out_reg.sv =====
// ----------------------------------------------------------------------------
// SFP LED result register
// Holds one result for the response channel until it is taken.
// ----------------------------------------------------------------------------
module sfpled_out_reg
   import sfpled_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load_valid,
   output logic    load_ready,
   input  rsp_type load_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // room when empty or the held result leaves this cycle
   assign load_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load_ready) begin
         valid_in = load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // load a fresh result on each transfer in
   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== tb/sfp_port_led_controller_core_test.sv =====
// ----------------------------------------------------------------------------
// SFP port LED controller core testbench
// Feeds poll ticks through the valid/stall request channel and checks every
// LED result against a cycle-free model of the port state held in a small
// scoreboard. Runs a directed sweep of insertion, cable detection, carrier and
// traffic cases, then random ticks under both activity owner settings, with
// bursty input, patterned output stalls and one long output hold per phase.
// ----------------------------------------------------------------------------
module sfp_port_led_controller_core_test;
   import sfpled_pkg::*;

   localparam int unsigned PHASE_TICKS    = 310;
   localparam int unsigned PRESSURE_TICKS = 40;
   localparam int unsigned HOLD_CYCLES    = 80;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned CYCLE_LIMIT    = 300000;
   localparam int unsigned REPORT_LIMIT   = 10;

   // Port state model and store of expected LED results
   class port_led_scoreboard;
      rsp_type     expected_leds[$];
      bit          external_owner;
      bit          present_seen;
      bit          carrier_seen;
      bit          cable_dac;
      bit          netdev_bound;
      bit          blink_phase;
      bit          link_level;
      bit          activity_level;
      bit [63:0]   prev_tx;
      bit [63:0]   prev_rx;
      int unsigned results_checked;
      int unsigned mismatches;

      function void set_owner(bit value);
         external_owner = value;
      endfunction

      function int unsigned pending();
         return expected_leds.size();
      endfunction

      // an external trigger owns the activity LED: leave its level alone
      function void set_activity(bit on);
         if (!external_owner) begin
            activity_level = on;
         end
      endfunction

      function void note_tick(req_type t);
         bit      carrier;
         rsp_type leds;
         // follow insertion and removal
         if (t.sfp_present != present_seen) begin
            present_seen = t.sfp_present;
            if (!t.sfp_present) begin
               link_level   = 1'b0;
               set_activity(1'b0);
               carrier_seen = 1'b0;
               cable_dac    = 1'b0;
            end else begin
               cable_dac  = t.id_read_ok &&
                            (((t.id_byte3 & COPPER_B3_MASK) != 8'h00) ||
                             ((t.id_byte8 & COPPER_B8_MASK) != 8'h00));
               link_level = 1'b0;
               set_activity(1'b1);
            end
         end
         if (t.sfp_present) begin
            // binding sticks once the interface has been found
            if (t.netdev_found) begin
               netdev_bound = 1'b1;
            end
            if (!netdev_bound) begin
               link_level = 1'b0;
               set_activity(1'b1);
            end else begin
               if (cable_dac) begin
                  carrier = t.oper_up;
               end else begin
                  carrier = t.diag_read_ok && ((t.diag_status & LOS_BIT_MASK) == 8'h00);
               end
               if (carrier != carrier_seen) begin
                  carrier_seen = carrier;
                  link_level   = carrier;
                  if (carrier) begin
                     set_activity(1'b0);
                     prev_tx     = '0;
                     prev_rx     = '0;
                     blink_phase = 1'b0;
                  end else begin
                     set_activity(1'b1);
                  end
               end
               // toggle on traffic, drop to off when idle
               if (carrier && t.if_running) begin
                  if (t.tx_count != prev_tx || t.rx_count != prev_rx) begin
                     blink_phase = !blink_phase;
                     set_activity(blink_phase);
                     prev_tx = t.tx_count;
                     prev_rx = t.rx_count;
                  end else if (blink_phase) begin
                     blink_phase = 1'b0;
                     set_activity(1'b0);
                  end
               end
            end
         end
         leds.link_lamp     = link_level;
         leds.activity_lamp = activity_level;
         leds.link_state    = carrier_seen;
         leds.dac_detected  = cable_dac;
         expected_leds.push_back(leds);
      endfunction

      function void check_leds(rsp_type got);
         rsp_type want;
         if (expected_leds.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("result with nothing expected: link %0b act %0b carrier %0b dac %0b",
                        got.link_lamp, got.activity_lamp, got.link_state, got.dac_detected);
            end
            return;
         end
         want = expected_leds.pop_front();
         results_checked++;
         if (got.link_lamp !== want.link_lamp || got.activity_lamp !== want.activity_lamp ||
             got.link_state !== want.link_state || got.dac_detected !== want.dac_detected) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("result %0d wrong: expected link %0b act %0b carrier %0b dac %0b",
                        results_checked, want.link_lamp, want.activity_lamp,
                        want.link_state, want.dac_detected);
               $display("                  got      link %0b act %0b carrier %0b dac %0b",
                        got.link_lamp, got.activity_lamp, got.link_state, got.dac_detected);
            end
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_write_enable;
   logic    csr_write_data;

   port_led_scoreboard scoreboard;
   bit                 hold_request;
   int unsigned        ticks_sent;
   int unsigned        owner_writes;

   // random tick generator state: a module that starts seated with a link
   bit                 gen_present = 1'b1;
   bit                 gen_link_good = 1'b1;
   bit [63:0]          gen_tx;
   bit [63:0]          gen_rx;

   sfp_port_led_controller_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic req_type make_tick(int unsigned present, int unsigned id_ok,
                                         logic [7:0] b3, logic [7:0] b8,
                                         int unsigned diag_ok, logic [7:0] diag,
                                         int unsigned found, int unsigned oper,
                                         int unsigned running,
                                         logic [63:0] tx, logic [63:0] rx);
      req_type t;
      t.sfp_present    = 1'(present);
      t.id_read_ok     = 1'(id_ok);
      t.id_byte3       = b3;
      t.id_byte8       = b8;
      t.diag_read_ok   = 1'(diag_ok);
      t.diag_status    = diag;
      t.netdev_found   = 1'(found);
      t.oper_up        = 1'(oper);
      t.if_running     = 1'(running);
      t.tx_count       = tx;
      t.rx_count       = rx;
      return t;
   endfunction

   function automatic req_type make_random_tick();
      req_type     t;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      // noise: every field at random
      if (pick < 10) begin
         t.sfp_present    = 1'($urandom);
         t.id_read_ok     = 1'($urandom);
         t.id_byte3       = 8'($urandom);
         t.id_byte8       = 8'($urandom);
         t.diag_read_ok   = 1'($urandom);
         t.diag_status    = 8'($urandom);
         t.netdev_found   = 1'($urandom);
         t.oper_up        = 1'($urandom);
         t.if_running     = 1'($urandom);
         t.tx_count       = {$urandom, $urandom};
         t.rx_count       = {$urandom, $urandom};
         return t;
      end
      // seat or pull the module and drop or raise the link now and then
      if ($urandom_range(0, 99) < 4) begin
         gen_present = !gen_present;
      end
      if ($urandom_range(0, 99) < 6) begin
         gen_link_good = !gen_link_good;
      end
      t.sfp_present    = gen_present;
      t.id_read_ok     = $urandom_range(0, 9) != 0;
      t.id_byte3       = 8'($urandom);
      t.id_byte8       = 8'($urandom);
      if ($urandom_range(0, 1) != 0) begin
         t.id_byte3 &= ~COPPER_B3_MASK;
         t.id_byte8 &= ~COPPER_B8_MASK;
      end
      t.diag_read_ok = $urandom_range(0, 19) != 0;
      t.diag_status  = 8'($urandom);
      if (gen_link_good) begin
         t.diag_status &= ~LOS_BIT_MASK;
      end else begin
         t.diag_status |= LOS_BIT_MASK;
      end
      t.netdev_found = 1'($urandom);
      t.oper_up      = ($urandom_range(0, 19) == 0) ? !gen_link_good : gen_link_good;
      t.if_running   = $urandom_range(0, 9) != 0;
      // counters: mostly idle or creeping, sometimes a jump, often near the top
      pick = $urandom_range(0, 99);
      if (pick >= 45 && pick < 70) begin
         gen_tx += 64'($urandom_range(1, 50));
      end else if (pick >= 70 && pick < 92) begin
         gen_rx += 64'($urandom_range(1, 50));
      end else if (pick >= 92) begin
         gen_tx = {($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : $urandom, $urandom};
         gen_rx = {($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : $urandom, $urandom};
      end
      t.tx_count = gen_tx;
      t.rx_count = gen_rx;
      return t;
   endfunction

   // offer one tick and hold it until the transfer
   task automatic send_tick(input req_type t);
      bit taken;
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = t;
      taken     = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
      end
      scoreboard.note_tick(t);
      ticks_sent++;
   endtask

   task automatic idle_gap(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
   endtask

   // drop valid and wait for every expected result to drain
   task automatic idle_wait();
      @(negedge clock);
      req_valid = 1'b0;
      while (scoreboard.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_owner(input bit value);
      idle_wait();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      scoreboard.set_owner(value);
      owner_writes++;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic run_phase(input bit owner);
      int unsigned sent;
      int unsigned burst;
      int unsigned i;
      write_owner(owner);
      // fill the block while the receiver holds off
      hold_request = 1'b1;
      for (i = 0; i < PRESSURE_TICKS; i++) begin
         send_tick(make_random_tick());
      end
      sent = PRESSURE_TICKS;
      while (sent < PHASE_TICKS) begin
         burst = $urandom_range(1, 24);
         for (i = 0; i < burst && sent < PHASE_TICKS; i++) begin
            send_tick(make_random_tick());
            sent++;
         end
         if ($urandom_range(0, 2) != 0) begin
            idle_gap($urandom_range(1, 8));
         end
      end
   endtask

   // receiver: stall on changing duty, with a long hold when asked
   initial begin
      int unsigned stall_pct;
      int unsigned mode_left;
      int unsigned hold_left;
      rsp_stall = 1'b0;
      stall_pct = 0;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            if (mode_left == 0) begin
               case ($urandom_range(0, 3))
                  0: begin
                     stall_pct = 0;
                  end
                  1: begin
                     stall_pct = 25;
                  end
                  2: begin
                     stall_pct = 50;
                  end
                  default: begin
                     stall_pct = 85;
                  end
               endcase
               mode_left = $urandom_range(4, 64);
            end
            mode_left--;
            rsp_stall = $urandom_range(0, 99) < stall_pct;
         end
      end
   end

   // check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         scoreboard.check_leds(rsp_data);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      req_type     directed_ticks[$];
      int unsigned phase;
      scoreboard       = new;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = 1'b0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      write_owner(1'b0);

      // insertion and cable type while no interface is bound, then carrier
      // and traffic once it is
      directed_ticks = '{
         make_tick(0, 0, 8'h00, 8'h00, 0, 8'h00, 0, 0, 0, '0, '0),
         make_tick(1, 0, 8'h03, 8'h0C, 1, 8'h00, 0, 1, 1, '0, '0),
         make_tick(0, 1, 8'hFF, 8'hFF, 1, 8'hFF, 0, 1, 1, '1, '1),
         make_tick(1, 1, 8'h01, 8'h00, 1, 8'h00, 0, 1, 1, '0, '0),
         make_tick(0, 1, 8'h00, 8'h00, 1, 8'h00, 0, 0, 0, '0, '0),
         make_tick(1, 1, 8'h02, 8'h00, 1, 8'h00, 0, 1, 1, '0, '0),
         make_tick(0, 1, 8'h00, 8'h00, 1, 8'h00, 0, 0, 0, '0, '0),
         make_tick(1, 1, 8'h00, 8'h04, 1, 8'h00, 0, 1, 1, '0, '0),
         make_tick(0, 1, 8'h00, 8'h00, 1, 8'h00, 0, 0, 0, '0, '0),
         make_tick(1, 1, 8'h00, 8'h08, 1, 8'h00, 0, 1, 1, '0, '0),
         make_tick(0, 1, 8'h00, 8'h00, 1, 8'h00, 0, 0, 0, '0, '0),
         make_tick(1, 1, 8'hFC, 8'hF3, 0, 8'h00, 0, 1, 1, '0, '0),
         make_tick(1, 1, 8'hFC, 8'hF3, 0, 8'h00, 1, 1, 1, '0, '0),
         make_tick(1, 1, 8'hFC, 8'hF3, 1, 8'h02, 0, 0, 1, '0, '0),
         make_tick(1, 1, 8'hFC, 8'hF3, 1, 8'hFD, 0, 0, 1, '0, '0),
         make_tick(1, 1, 8'hFC, 8'hF3, 1, 8'hFD, 0, 0, 1, '1, '0),
         make_tick(1, 1, 8'hFC, 8'hF3, 1, 8'hFD, 0, 0, 1, '1, '1),
         make_tick(1, 1, 8'hFC, 8'hF3, 1, 8'hFD, 0, 0, 1, '0, '1),
         make_tick(1, 1, 8'hFC, 8'hF3, 1, 8'hFD, 0, 0, 1, '0, '1),
         make_tick(1, 1, 8'hFC, 8'hF3, 1, 8'hFD, 0, 0, 0, 64'd9, 64'd9),
         make_tick(1, 1, 8'hFC, 8'hF3, 1, 8'hFF, 0, 0, 1, 64'd9, 64'd9),
         make_tick(0, 0, 8'h00, 8'h00, 0, 8'h00, 0, 0, 0, '0, '0),
         make_tick(1, 1, 8'h01, 8'h00, 0, 8'hFF, 0, 1, 1, 64'd5, 64'd5),
         make_tick(1, 1, 8'h01, 8'h00, 0, 8'hFF, 0, 0, 1, 64'd5, 64'd5),
         make_tick(1, 1, 8'hFF, 8'hFF, 1, 8'hFF, 1, 1, 1, '1, '1)
      };
      foreach (directed_ticks[i]) begin
         send_tick(directed_ticks[i]);
         if ($urandom_range(0, 3) == 0) begin
            idle_gap($urandom_range(1, 3));
         end
      end

      // alternate the activity owner across the random phases
      for (phase = 0; phase < 4; phase++) begin
         run_phase(phase[0] == 1'b0);
      end
      idle_wait();

      $display("covered %0d poll ticks (%0d directed) across %0d activity owner writes",
               ticks_sent, directed_ticks.size(), owner_writes);
      $display("compared %0d LED results; output held off %0d cycles in each random phase",
               scoreboard.results_checked, HOLD_CYCLES);
      if (scoreboard.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
